// ===== rtl/core/irqpc_pkg.sv =====
// ----------------------------------------------------------------------------
// irqpc_pkg
// Types, codes and constants shared by the prescaled IRQ counter modules.
// ----------------------------------------------------------------------------
package irqpc_pkg;

    // Input item kinds.
    typedef enum logic [1:0] {
        MODE_CPU_CYCLES = 2'd0,
        MODE_CPU_WRITE  = 2'd1,
        MODE_PPU_ADDR   = 2'd2,
        MODE_SCANLINE   = 2'd3
    } t_mode;

    // Clock source selected by control bits 1:0.
    typedef enum logic [1:0] {
        SRC_CPU_CYCLES = 2'd0,
        SRC_SCANLINE   = 2'd1,
        SRC_PPU_ADDR   = 2'd2,
        SRC_CPU_WRITE  = 2'd3
    } t_src;

    // Prescaler direction from control bits 7:6.
    typedef enum logic [1:0] {
        DIR_HOLD_A = 2'd0,
        DIR_UP     = 2'd1,
        DIR_DOWN   = 2'd2,
        DIR_HOLD_B = 2'd3
    } t_dir;

    // Register index from address bits 2:0.
    typedef enum logic [2:0] {
        REG_ENABLE     = 3'd0,
        REG_CONTROL    = 3'd1,
        REG_DISABLE    = 3'd2,
        REG_ENABLE_SET = 3'd3,
        REG_PRESCALE   = 3'd4,
        REG_COUNTER    = 3'd5,
        REG_XOR        = 3'd6,
        REG_RESERVED   = 3'd7
    } t_reg_idx;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    localparam logic [3:0] REG_PAGE      = 4'hC;
    localparam logic [7:0] MASK_SHORT    = 8'h07;
    localparam logic [7:0] MASK_FULL     = 8'hFF;
    localparam logic [7:0] COUNT_TOP     = 8'hFF;
    localparam logic [7:0] COUNT_BOTTOM  = 8'h00;
    localparam logic [7:0] STEPS_WRITE   = 8'd1;
    localparam logic [7:0] STEPS_PPU     = 8'd2;
    localparam logic [7:0] STEPS_LINE    = 8'd8;

    // Timer state that one prescaler step reads and writes.
    typedef struct packed {
        logic       enable;
        logic [7:0] control;
        logic [7:0] prescale;
        logic [7:0] events;
        logic       pending;
    } t_timer;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] address;
        logic [7:0]  value;
        logic [7:0]  cycle_count;
    } t_in_item;

    typedef struct packed {
        logic       irq;
        logic [7:0] counter_value;
        logic [7:0] prescaler_value;
    } t_out_item;

endpackage

// ===== rtl/core/irqpc_tick.sv =====
// ----------------------------------------------------------------------------
// irqpc_tick
// One prescaler step if enabled; counter moves on roll over if !control[3].
// ----------------------------------------------------------------------------
module irqpc_tick
    import irqpc_pkg::*;
(
    input  t_timer i_cur,
    output t_timer o_nxt
);

    logic [7:0] w_mask;
    logic [7:0] w_pre;
    logic [7:0] w_pre_step;
    logic [7:0] w_events;
    logic       w_roll;
    t_dir       w_dir;

    // Masked prescaler step in the selected direction.
    always_comb begin
        w_mask     = i_cur.control[2] ? MASK_SHORT : MASK_FULL;
        w_dir      = t_dir'(i_cur.control[7:6]);
        w_pre      = i_cur.prescale & w_mask;
        w_pre_step = w_pre;
        w_roll     = 1'b0;
        case (w_dir)
            DIR_UP: begin
                w_pre_step = w_pre + 8'd1;
                w_roll     = ((w_pre_step & w_mask) == 8'd0);
            end
            DIR_DOWN: begin
                w_pre_step = w_pre - 8'd1;
                w_roll     = (w_pre_step == 8'd0);
            end
            default: begin
                w_pre_step = w_pre;
                w_roll     = 1'b0;
            end
        endcase
    end

    // Counter move and IRQ flag on roll over.
    always_comb begin
        o_nxt    = i_cur;
        w_events = i_cur.events;
        if (i_cur.enable) begin
            o_nxt.prescale = (i_cur.prescale & ~w_mask) | (w_pre_step & w_mask);
            if (w_roll) begin
                if (w_dir == DIR_UP) begin
                    if (!i_cur.control[3]) begin
                        w_events = i_cur.events + 8'd1;
                    end
                    if (w_events == COUNT_BOTTOM) begin
                        o_nxt.pending = 1'b1;
                    end
                end else begin
                    if (!i_cur.control[3]) begin
                        w_events = i_cur.events - 8'd1;
                    end
                    if (w_events == COUNT_TOP) begin
                        o_nxt.pending = 1'b1;
                    end
                end
                o_nxt.events = w_events;
            end
        end
    end

endmodule

// ===== rtl/core/irq_prescaled_counter.sv =====
// ----------------------------------------------------------------------------
// irq_prescaled_counter
// Cartridge IRQ timer with a programmable prescaler and an 8-bit counter.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the input channel (i_valid / o_ready, payload i_data):
// CPU cycle batches, CPU writes, PPU address changes and scanline ends.
// Each item yields exactly one result on the output channel (o_valid /
// i_ready, payload o_data): the IRQ level, the counter and the prescaler
// after the item.
// Work is done by one prescaler step unit that runs once per cycle. An item
// needing N steps (N = the batch size for a CPU cycle batch, STEPS_WRITE for
// a CPU write, STEPS_PPU for a changed PPU address, STEPS_LINE for a
// scanline, none when its source is not selected) runs its steps in turn
// and then loads its result into the output register; o_ready is high only
// while idle, so the next item is taken only after the result is loaded.
// A CPU write to C000-CFFF is applied after its step.
// Reset clears the whole timer state and drops o_valid. When the receiver
// stalls, the result waits in the output register; a finished item holds
// the sequencer until that register is free.
// ----------------------------------------------------------------------------
module irq_prescaled_counter
    import irqpc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    t_state     r_state, n_state;
    t_timer     r_timer, n_timer;
    t_timer     w_tick_nxt;
    t_timer     w_written;
    t_in_item   r_item;
    logic [7:0] r_steps, n_steps;
    logic [7:0] r_load_xor, n_load_xor;
    logic [15:0] r_prev_addr, n_prev_addr;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out, n_out;
    logic       w_accept;
    logic       w_tick_en;
    logic       w_finish;
    logic [7:0] w_in_steps;
    t_src       w_src;
    t_reg_idx   w_reg;

    irqpc_tick u_tick (
        .i_cur (r_timer),
        .o_nxt (w_tick_nxt)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_steps == 8'd0 && (!r_out_valid || i_ready)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_ready   = 1'b0;
        w_tick_en = 1'b0;
        w_finish  = 1'b0;
        case (r_state)
            ST_IDLE: o_ready = 1'b1;
            ST_RUN: begin
                w_tick_en = (r_steps != 8'd0);
                w_finish  = (r_steps == 8'd0) && (!r_out_valid || i_ready);
            end
            default: o_ready = 1'b0;
        endcase
    end

    assign w_accept = i_valid && o_ready;
    assign w_src    = t_src'(r_timer.control[1:0]);
    assign w_reg    = t_reg_idx'(r_item.address[2:0]);

    // Step count of a new item.
    always_comb begin
        w_in_steps = 8'd0;
        case (t_mode'(i_data.mode))
            MODE_CPU_CYCLES: begin
                if (w_src == SRC_CPU_CYCLES) w_in_steps = i_data.cycle_count;
            end
            MODE_CPU_WRITE: begin
                if (w_src == SRC_CPU_WRITE) w_in_steps = STEPS_WRITE;
            end
            MODE_PPU_ADDR: begin
                if (w_src == SRC_PPU_ADDR && i_data.address != r_prev_addr) begin
                    w_in_steps = STEPS_PPU;
                end
            end
            MODE_SCANLINE: begin
                if (w_src == SRC_SCANLINE) w_in_steps = STEPS_LINE;
            end
            default: w_in_steps = 8'd0;
        endcase
    end

    // Register write of a CPU write item, applied after its step.
    always_comb begin
        w_written  = r_timer;
        n_load_xor = r_load_xor;
        if (t_mode'(r_item.mode) == MODE_CPU_WRITE && r_item.address[15:12] == REG_PAGE) begin
            case (w_reg)
                REG_ENABLE: begin
                    w_written.enable = r_item.value[0];
                    if (!r_item.value[0]) begin
                        w_written.prescale = 8'd0;
                        w_written.pending  = 1'b0;
                    end
                end
                REG_CONTROL:    w_written.control = r_item.value;
                REG_DISABLE: begin
                    w_written.enable   = 1'b0;
                    w_written.prescale = 8'd0;
                    w_written.pending  = 1'b0;
                end
                REG_ENABLE_SET: w_written.enable   = 1'b1;
                REG_PRESCALE:   w_written.prescale = r_item.value ^ r_load_xor;
                REG_COUNTER:    w_written.events   = r_item.value ^ r_load_xor;
                REG_XOR:        n_load_xor         = r_item.value;
                default:        w_written          = r_timer;
            endcase
        end
        if (!w_finish) begin
            n_load_xor = r_load_xor;
        end
    end

    // Timer state, step counter and result register.
    always_comb begin
        n_timer     = r_timer;
        n_steps     = r_steps;
        n_prev_addr = r_prev_addr;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        if (w_accept) begin
            n_steps = w_in_steps;
            if (t_mode'(i_data.mode) == MODE_PPU_ADDR) begin
                n_prev_addr = i_data.address;
            end
        end
        if (w_tick_en) begin
            n_timer = w_tick_nxt;
            n_steps = r_steps - 8'd1;
        end
        if (w_finish) begin
            n_timer     = w_written;
            n_out_valid = 1'b1;
            n_out.irq             = w_written.pending;
            n_out.counter_value   = w_written.events;
            n_out.prescaler_value = w_written.prescale;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_timer     <= '0;
            r_steps     <= 8'd0;
            r_load_xor  <= 8'd0;
            r_prev_addr <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_timer     <= n_timer;
            r_steps     <= n_steps;
            r_load_xor  <= n_load_xor;
            r_prev_addr <= n_prev_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_data;
        end
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== rtl/core/irqpc_checker.sv =====
// ----------------------------------------------------------------------------
// irqpc_checker
// Port-level checks of the prescaled IRQ counter, bound to the top level.
// ----------------------------------------------------------------------------
module irqpc_checker
    import irqpc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input t_in_item  i_data,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_data
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // The block drops ready in the cycle after each input transfer.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after an input transfer");

    // A new result is only loaded while the block is working on an item.
    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result appeared while idle");

    // The result payload changes only when a result is shown.
    a_payload_with_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !$stable(o_data) |-> $past(!o_ready))
        else $error("result payload changed without an item in work");

endmodule

bind irq_prescaled_counter irqpc_checker u_irqpc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
